>>> rtl/rdtt_pkg.sv
// Shared constants and types for the request deadline timer table.
// No dependencies.
`default_nettype none
package rdtt_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_ARMED     = 3'd0,
    K_CANCELLED = 3'd1,
    K_EXPIRED   = 3'd2,
    K_QUERY     = 3'd3,
    K_TICK_NONE = 3'd4,
    K_FULL      = 3'd5
  } kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] req_id;
    logic [31:0] timeout;
  } cmd_word_t;
endpackage
`default_nettype wire

>>> rtl/rdtt_front.sv
// Intake stage and two-entry command queue for the deadline timer table.
// Depends on rdtt_pkg.
`default_nettype none
module rdtt_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rdtt_pkg::cmd_word_t in_word,
  output logic                    q_valid,
  output rdtt_pkg::cmd_word_t     q_word,
  input  wire logic               q_take
);
  rdtt_pkg::cmd_word_t buf0, buf1;
  logic [1:0] fill;
  logic push, pop;

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_take && (fill != 2'd0);
  assign q_valid = (fill != 2'd0);
  assign q_word = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      buf0 <= (fill == 2'd2) ? buf1 : in_word;
      if (push && fill == 2'd2) buf1 <= in_word;
    end else if (push) begin
      if (fill == 2'd0) buf0 <= in_word;
      else buf1 <= in_word;
    end
  end
endmodule
`default_nettype wire

>>> rtl/rdtt_back.sv
// Table engine: slot lookup, arm, cancel, query and one-slot-a-cycle expiry scan, paused while each word is held.
// Depends on rdtt_pkg.
`default_nettype none
module rdtt_back #(
  parameter int ENTRIES = rdtt_pkg::ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire rdtt_pkg::cmd_word_t q_word,
  output logic                     q_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               kind,
  output logic [31:0]              req_id_out,
  output logic                     present,
  output logic [4:0]               pending,
  output logic                     last
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = rdtt_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  logic [ENTRIES-1:0] slot_valid;
  logic [31:0] slot_tag [ENTRIES];
  logic [TW-1:0] slot_deadline [ENTRIES];
  logic [TW-1:0] now_ticks;
  logic [CW-1:0] armed_count;
  logic [IW-1:0] scan_idx;
  logic any_hit;
  logic scan_ret;

  logic [ENTRIES-1:0] hit_vec;
  logic hit;
  logic [IW-1:0] hit_idx;
  logic free;
  logic [IW-1:0] free_idx;
  logic [TW:0] dl_sum;
  logic [TW-1:0] dl;
  logic due;
  logic later_due;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid[i] && (slot_tag[i] == q_word.req_id);
      if (hit_vec[i]) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
      if (!slot_valid[i]) begin
        free = 1'b1;
        free_idx = IW'(i);
      end
    end
    later_due = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (IW'(i) > scan_idx && slot_valid[i] && slot_deadline[i] <= now_ticks)
        later_due = 1'b1;
    end
  end

  assign dl_sum = {1'b0, now_ticks} + {{(TW - 31){1'b0}}, q_word.timeout};
  assign dl = dl_sum[TW] ? rdtt_pkg::TIME_MAX : dl_sum[TW-1:0];
  assign due = slot_valid[scan_idx] && slot_deadline[scan_idx] <= now_ticks;
  assign out_valid = (state == S_OUT);
  assign q_take = (state == S_IDLE) && q_valid;
  assign pending = 5'(armed_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      now_ticks <= '0;
      armed_count <= '0;
      scan_idx <= '0;
      any_hit <= 1'b0;
      scan_ret <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            req_id_out <= q_word.req_id;
            present <= 1'b0;
            last <= 1'b1;
            scan_ret <= 1'b0;
            state <= S_OUT;
            case (q_word.cmd)
              rdtt_pkg::CMD_ARM: begin
                if (hit) begin
                  slot_deadline[hit_idx] <= dl;
                  kind <= rdtt_pkg::K_ARMED;
                end else if (free) begin
                  slot_valid[free_idx] <= 1'b1;
                  slot_tag[free_idx] <= q_word.req_id;
                  slot_deadline[free_idx] <= dl;
                  armed_count <= armed_count + 1'b1;
                  kind <= rdtt_pkg::K_ARMED;
                end else begin
                  kind <= rdtt_pkg::K_FULL;
                end
              end
              rdtt_pkg::CMD_CANCEL: begin
                kind <= rdtt_pkg::K_CANCELLED;
                present <= hit;
                if (hit) begin
                  slot_valid[hit_idx] <= 1'b0;
                  armed_count <= armed_count - 1'b1;
                end
              end
              rdtt_pkg::CMD_QUERY: begin
                kind <= rdtt_pkg::K_QUERY;
                present <= hit;
              end
              default: begin
                if (now_ticks != rdtt_pkg::TIME_MAX) now_ticks <= now_ticks + 1'b1;
                scan_idx <= '0;
                any_hit <= 1'b0;
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (due) begin
            slot_valid[scan_idx] <= 1'b0;
            armed_count <= armed_count - 1'b1;
            kind <= rdtt_pkg::K_EXPIRED;
            req_id_out <= slot_tag[scan_idx];
            present <= 1'b0;
            last <= !later_due;
            any_hit <= 1'b1;
            scan_ret <= later_due;
            state <= S_OUT;
          end else if (32'(scan_idx) == ENTRIES - 1) begin
            if (!any_hit) begin
              kind <= rdtt_pkg::K_TICK_NONE;
              req_id_out <= '0;
              present <= 1'b0;
              last <= 1'b1;
              scan_ret <= 1'b0;
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
          if (!due || !later_due) begin
            if (32'(scan_idx) != ENTRIES - 1) scan_idx <= scan_idx + 1'b1;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= scan_ret ? S_SCAN : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/request_deadline_timer_table.sv
// Request deadline timer table: arm, cancel, query and tick with expiry reporting.
// Arm, cancel and query each give one word, registered through the command queue and the table engine.
// The engine takes the next arm, cancel or query only once the word of the last one is given.
// Tick scans one slot a cycle, pausing on each word it gives until that word is taken.
// A two-word command queue keeps intake open while the table engine works.
// Synchronous active-high reset empties the table and zeroes the clock.
// Depends on rdtt_pkg, rdtt_front, rdtt_back.
`default_nettype none
module request_deadline_timer_table #(
  parameter int ENTRIES = rdtt_pkg::ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] req_id,
  input  wire logic [31:0] timeout,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [31:0]      req_id_out,
  output logic             present,
  output logic [4:0]       pending,
  output logic             last
);
  rdtt_pkg::cmd_word_t in_word, q_word;
  logic q_valid, q_take;

  assign in_word.cmd = rdtt_pkg::cmd_t'(cmd);
  assign in_word.req_id = req_id;
  assign in_word.timeout = timeout;

  rdtt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .q_valid(q_valid), .q_word(q_word), .q_take(q_take)
  );

  rdtt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .q_take(q_take),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .req_id_out(req_id_out), .present(present), .pending(pending), .last(last)
  );
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for request_deadline_timer_table: arm, cancel, query and tick traffic
// checked word by word against a behavioural table model, under random idling and stalls.
// Depends on rdtt_pkg and the request_deadline_timer_table RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS = rdtt_pkg::ENTRIES_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int RX_HOLD_LEN = 400;

  typedef struct {
    rdtt_pkg::cmd_t cmd;
    logic [31:0]    id;
    logic [31:0]    tmo;
  } cmd_item_t;

  typedef struct {
    rdtt_pkg::kind_t kind;
    logic [31:0]     id;
    logic            present;
    logic [4:0]      pending;
    logic            last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = rdtt_pkg::CMD_TICK;
  logic [31:0] req_id = '0;
  logic [31:0] timeout = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [31:0] req_id_out;
  logic        present;
  logic [4:0]  pending;
  logic        last;

  request_deadline_timer_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .req_id(req_id), .timeout(timeout),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .req_id_out(req_id_out), .present(present),
    .pending(pending), .last(last)
  );

  always #4 clk = ~clk;

  // table model
  logic        tbl_valid [N_SLOTS];
  logic [31:0] tbl_tag [N_SLOTS];
  logic [47:0] tbl_deadline [N_SLOTS];
  logic [47:0] tbl_now;
  logic [4:0]  tbl_count;

  cmd_item_t pending_cmds[$];
  result_t   expected_words[$];
  int        errors = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        rx_long = 0;
  int        rx_hold_cnt = 0;
  int        quiet_cycles = 0;
  cmd_item_t nxt;
  result_t   got;

  function automatic int find_tag(logic [31:0] id);
    for (int i = 0; i < N_SLOTS; i++)
      if (tbl_valid[i] && tbl_tag[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_word(rdtt_pkg::kind_t k, logic [31:0] id, logic p, logic l);
    result_t r;
    r.kind = k; r.id = id; r.present = p; r.pending = tbl_count; r.last = l;
    expected_words = {expected_words, r};
  endfunction

  function automatic void table_step(rdtt_pkg::cmd_t c, logic [31:0] id, logic [31:0] tmo);
    logic [48:0] sum;
    int slot;
    int n;
    case (c)
      rdtt_pkg::CMD_ARM: begin
        sum = {1'b0, tbl_now} + {17'd0, tmo};
        slot = find_tag(id);
        if (slot < 0) begin
          for (int i = 0; i < N_SLOTS; i++)
            if (!tbl_valid[i]) begin slot = i; break; end
          if (slot < 0) begin
            push_word(rdtt_pkg::K_FULL, id, 1'b0, 1'b1);
            return;
          end
          tbl_valid[slot] = 1'b1;
          tbl_tag[slot] = id;
          tbl_count++;
        end
        tbl_deadline[slot] = sum[48] ? rdtt_pkg::TIME_MAX : sum[47:0];
        push_word(rdtt_pkg::K_ARMED, id, 1'b0, 1'b1);
      end
      rdtt_pkg::CMD_CANCEL: begin
        slot = find_tag(id);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          tbl_count--;
        end
        push_word(rdtt_pkg::K_CANCELLED, id, slot >= 0, 1'b1);
      end
      rdtt_pkg::CMD_QUERY: push_word(rdtt_pkg::K_QUERY, id, find_tag(id) >= 0, 1'b1);
      default: begin
        if (tbl_now != rdtt_pkg::TIME_MAX) tbl_now++;
        n = 0;
        for (int i = 0; i < N_SLOTS; i++)
          if (tbl_valid[i] && tbl_deadline[i] <= tbl_now) begin
            tbl_valid[i] = 1'b0;
            tbl_count--;
            push_word(rdtt_pkg::K_EXPIRED, tbl_tag[i], 1'b0, 1'b0);
            n++;
          end
        if (n == 0) push_word(rdtt_pkg::K_TICK_NONE, '0, 1'b0, 1'b1);
        else expected_words[$].last = 1'b1;
      end
    endcase
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void add(rdtt_pkg::cmd_t c, logic [31:0] id, logic [31:0] tmo);
    cmd_item_t it;
    it.cmd = c; it.id = id; it.tmo = tmo;
    pending_cmds = {pending_cmds, it};
  endfunction

  function automatic void add_random(bit calm);
    int sel;
    rdtt_pkg::cmd_t c;
    logic [31:0] id;
    logic [31:0] tmo;
    sel = $urandom_range(99);
    if (calm) begin
      c = sel < 45 ? rdtt_pkg::CMD_ARM : sel < 60 ? rdtt_pkg::CMD_CANCEL : rdtt_pkg::CMD_QUERY;
    end else begin
      c = sel < 35 ? rdtt_pkg::CMD_ARM : sel < 50 ? rdtt_pkg::CMD_CANCEL :
          sel < 80 ? rdtt_pkg::CMD_TICK : rdtt_pkg::CMD_QUERY;
    end
    id = $urandom_range(99) < 85 ? 32'(32'hA5A5_0000 + $urandom_range(19)) : $urandom;
    sel = $urandom_range(99);
    tmo = sel < 70 ? 32'($urandom_range(8)) : sel < 90 ? 32'($urandom_range(40)) : $urandom;
    add(c, id, tmo);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) table_step(rdtt_pkg::cmd_t'(cmd), req_id, timeout);
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.cmd;
          req_id <= nxt.id;
          timeout <= nxt.tmo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_long && rx_hold_cnt < RX_HOLD_LEN) begin
      out_stall <= 1'b1;
      rx_hold_cnt <= rx_hold_cnt + 1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d id %h", kind, req_id_out));
      end else begin
        got = expected_words.pop_front();
        if (kind !== got.kind) report($sformatf("kind %0d, want %0d", kind, got.kind));
        if (req_id_out !== got.id) report($sformatf("id %h, want %h", req_id_out, got.id));
        if (present !== got.present) report($sformatf("present %b, want %b", present, got.present));
        if (pending !== got.pending) report($sformatf("pending %0d, want %0d", pending, got.pending));
        if (last !== got.last) report($sformatf("last %b, want %b", last, got.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
    tbl_now = '0;
    tbl_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, zero and full-scale fields, re-arm, expiry, full table
    add(rdtt_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(rdtt_pkg::CMD_QUERY, 32'd5, '0);
    add(rdtt_pkg::CMD_CANCEL, 32'd5, '0);
    add(rdtt_pkg::CMD_ARM, 32'd0, 32'd0);
    add(rdtt_pkg::CMD_ARM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(rdtt_pkg::CMD_ARM, 32'd7, 32'd3);
    add(rdtt_pkg::CMD_ARM, 32'd7, 32'd1);
    add(rdtt_pkg::CMD_QUERY, 32'd7, '0);
    add(rdtt_pkg::CMD_TICK, '0, '0);
    add(rdtt_pkg::CMD_TICK, '0, '0);
    for (int i = 0; i < N_SLOTS - 1; i++)
      add(rdtt_pkg::CMD_ARM, 32'(100 + i), 32'(2 + i % 3));
    add(rdtt_pkg::CMD_ARM, 32'd200, 32'd1);
    add(rdtt_pkg::CMD_ARM, 32'd100, 32'd9);
    add(rdtt_pkg::CMD_CANCEL, 32'hFFFF_FFFF, '0);
    add(rdtt_pkg::CMD_TICK, '0, '0);
    add(rdtt_pkg::CMD_TICK, '0, '0);
    drain();

    tx_idle_pct = 81; rx_idle_pct = 0;
    repeat (40) add_random(0);
    drain();

    tx_idle_pct = 0; rx_idle_pct = 81;
    repeat (40) add_random(0);
    drain();

    tx_idle_pct = 33; rx_idle_pct = 33;
    repeat (40) add_random(0);
    drain();

    // long receiver hold while intake keeps offering
    tx_idle_pct = 0; rx_idle_pct = 0; rx_long = 1;
    repeat (30) add_random(1);
    repeat (10) add(rdtt_pkg::CMD_TICK, $urandom, $urandom);
    drain();

    tx_idle_pct = 0; rx_idle_pct = 0;
    repeat (40) add_random(0);
    drain();

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> request_deadline_timer_table.f
rtl/rdtt_pkg.sv
rtl/rdtt_front.sv
rtl/rdtt_back.sv
rtl/request_deadline_timer_table.sv
bench/tb_top.sv
